FILE: rtl/core/ahil_pkg.sv
// ----------------------------------------------------------------------------
// ahil_pkg: shared types and constants for the ASCII hex image loader
// Holds the character codes that the digit decoder uses and the layout of
// the load header.
// ----------------------------------------------------------------------------
package ahil_pkg;

  typedef logic [7:0] char_t;
  typedef logic [3:0] nibble_t;

  localparam char_t CharZero   = 8'h30;
  localparam char_t CharNine   = 8'h39;
  localparam char_t CharUpperA = 8'h41;
  localparam char_t CharUpperF = 8'h46;
  localparam char_t CharLowerA = 8'h61;

  // Value of the letter A as a hex digit.
  localparam nibble_t LetterValue = 4'd10;

  // The header holds four count digits followed by four address digits.
  localparam int unsigned CountDigits  = 4;
  localparam int unsigned HeaderDigits = 8;

  localparam int unsigned WordAddrW = 15;

endpackage

FILE: rtl/core/ascii_hex_image_loader_core.sv
// ----------------------------------------------------------------------------
// ascii_hex_image_loader_core: ASCII hex object image loader
// Decodes a stream of hex characters into byte writes for a 16-bit-word
// memory.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i, in_ready_o, char_code_i) carries one
//   character per transfer. The first eight digits form the header: a 16-bit
//   byte count and then a 16-bit start byte address, most significant digit
//   first. Each later pair of digits produces one write on the output channel
//   (word_address_o, byte_lane_o, first_nibble_o, second_nibble_o,
//   last_byte_o), with last_byte_o set on the final byte of the load.
//   A write is loaded into the result register at the edge that accepts the
//   character completing its byte and is offered from the next cycle.
//   Throughput is one character per cycle; the only limit is the single
//   result register, which frees as the output transfer happens, so
//   in_ready_o stays high while out_ready_i is high. When the receiver
//   stalls with a write held, in_ready_o drops until that write is taken.
//   A zero count ends the load with no writes. Characters after the end of
//   the load are accepted and dropped. Reset clears the header progress, the
//   counters and the result valid flag.
// ----------------------------------------------------------------------------
module ascii_hex_image_loader_core #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [14:0] word_address_o,
  output logic        byte_lane_o,
  output logic [3:0]  first_nibble_o,
  output logic [3:0]  second_nibble_o,
  output logic        last_byte_o
);

  localparam int unsigned SumW = 17;
  localparam logic [SumW-1:0] AddrMask =
      (ADDR_BITS >= SumW) ? {SumW{1'b1}} : SumW'((64'd1 << ADDR_BITS) - 64'd1);

  ahil_pkg::nibble_t digit;

  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic        data_phase_q, data_phase_d;
  logic [15:0] byte_count_q, byte_count_d;
  logic [15:0] start_addr_q, start_addr_d;
  logic [15:0] offset_q, offset_d;
  ahil_pkg::nibble_t held_q, held_d;
  logic        pending_q, pending_d;
  logic        finished_q, finished_d;

  logic        out_valid_q, out_valid_d;
  logic [14:0] word_addr_q;
  logic        lane_q;
  ahil_pkg::nibble_t first_q, second_q;
  logic        last_q;

  logic            take;
  logic            emit;
  logic [SumW-1:0] byte_addr;
  logic            is_last;

  ahil_digit_decode u_decode (
    .char_i  (char_code_i),
    .digit_o (digit)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  assign byte_addr = ({1'b0, start_addr_q} + {1'b0, offset_q}) & AddrMask;
  assign is_last   = ({1'b0, offset_q} + 17'd1) >= {1'b0, byte_count_q};

  always_comb begin
    hdr_cnt_d    = hdr_cnt_q;
    data_phase_d = data_phase_q;
    byte_count_d = byte_count_q;
    start_addr_d = start_addr_q;
    offset_d     = offset_q;
    held_d       = held_q;
    pending_d    = pending_q;
    finished_d   = finished_q;
    emit         = 1'b0;
    if (take && !finished_q) begin
      if (!data_phase_q) begin
        if (hdr_cnt_q < 3'(ahil_pkg::CountDigits)) begin
          byte_count_d = {byte_count_q[11:0], digit};
        end else begin
          start_addr_d = {start_addr_q[11:0], digit};
        end
        if (hdr_cnt_q == 3'(ahil_pkg::HeaderDigits - 1)) begin
          hdr_cnt_d    = '0;
          data_phase_d = 1'b1;
          if (byte_count_q == '0) begin
            finished_d = 1'b1;
          end
        end else begin
          hdr_cnt_d = hdr_cnt_q + 3'd1;
        end
      end else if (!pending_q) begin
        held_d    = digit;
        pending_d = 1'b1;
      end else begin
        emit      = 1'b1;
        pending_d = 1'b0;
        offset_d  = offset_q + 16'd1;
        if (is_last) begin
          finished_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q    <= '0;
      data_phase_q <= 1'b0;
      byte_count_q <= '0;
      start_addr_q <= '0;
      offset_q     <= '0;
      held_q       <= '0;
      pending_q    <= 1'b0;
      finished_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      hdr_cnt_q    <= hdr_cnt_d;
      data_phase_q <= data_phase_d;
      byte_count_q <= byte_count_d;
      start_addr_q <= start_addr_d;
      offset_q     <= offset_d;
      held_q       <= held_d;
      pending_q    <= pending_d;
      finished_q   <= finished_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // The result payload only changes when a new write is produced.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      word_addr_q <= byte_addr[ahil_pkg::WordAddrW:1];
      lane_q      <= byte_addr[0];
      first_q     <= held_q;
      second_q    <= digit;
      last_q      <= is_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign word_address_o  = word_addr_q;
  assign byte_lane_o     = lane_q;
  assign first_nibble_o  = first_q;
  assign second_nibble_o = second_q;
  assign last_byte_o     = last_q;

  // A held write flagged as last means the load has already been closed.
  a_last_closes_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> finished_q)
    else $error("last byte held while load still open");

  a_finished_sticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |=> finished_q)
    else $error("finished flag cleared without reset");

  a_no_nibble_in_header : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !data_phase_q |-> !pending_q)
    else $error("nibble pending during header");

  a_no_write_after_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |=> !emit)
    else $error("write produced after end of load");

endmodule

FILE: rtl/core/ahil_digit_decode.sv
// ----------------------------------------------------------------------------
// ahil_digit_decode: ASCII character to hex digit value
// Decimal digits and uppercase A to F map to their values. Every other code,
// lowercase letters included, is treated as an offset from lowercase a.
// ----------------------------------------------------------------------------
module ahil_digit_decode (
  input  ahil_pkg::char_t   char_i,
  output ahil_pkg::nibble_t digit_o
);

  logic is_decimal;
  logic is_upper;

  assign is_decimal = (char_i >= ahil_pkg::CharZero) && (char_i <= ahil_pkg::CharNine);
  assign is_upper   = (char_i >= ahil_pkg::CharUpperA) && (char_i <= ahil_pkg::CharUpperF);

  always_comb begin
    if (is_decimal) begin
      digit_o = 4'(char_i - ahil_pkg::CharZero);
    end else if (is_upper) begin
      digit_o = 4'(char_i - ahil_pkg::CharUpperA) + ahil_pkg::LetterValue;
    end else begin
      digit_o = 4'(char_i - ahil_pkg::CharLowerA) + ahil_pkg::LetterValue;
    end
  end

endmodule
